/* rtl/rrs_pkg.sv */
package rrs_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned DELAY_W  = 24;
    localparam int unsigned OPT_W    = 2;
    localparam int unsigned REG_IDX_W = 3;

    localparam logic [TIME_W-1:0] SCALE_FACTOR = 32'd64;
    localparam int unsigned       SCALE_SHIFT  = 8;
    localparam int unsigned       PHASE_BIT    = 7;     // bit of now that toggles the AC relays

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TRIGGER_HOLD = 3'd0,
        REG_SIGNAL_DELAY = 3'd1,
        REG_SIGNAL_HOLD  = 3'd2,
        REG_RESET_DELAY  = 3'd3,
        REG_BUTTON_DELAY = 3'd4,
        REG_RELAY_PHASE  = 3'd5,
        REG_REARM_WAIT   = 3'd6,
        REG_OPTIONS      = 3'd7
    } t_reg_idx;

    localparam logic [DELAY_W-1:0] RST_TRIGGER_HOLD = 24'd500;
    localparam logic [DELAY_W-1:0] RST_SIGNAL_DELAY = 24'd2000;
    localparam logic [DELAY_W-1:0] RST_SIGNAL_HOLD  = 24'd5000;
    localparam logic [DELAY_W-1:0] RST_RESET_DELAY  = 24'd4000;
    localparam logic [DELAY_W-1:0] RST_BUTTON_DELAY = 24'd1000;
    localparam logic [DELAY_W-1:0] RST_RELAY_PHASE  = 24'd2000;
    localparam logic [DELAY_W-1:0] RST_REARM_WAIT   = 24'd1000;
    localparam logic [OPT_W-1:0]   RST_OPTIONS      = 2'd1;

    localparam int unsigned OPT_LAMP   = 0;
    localparam int unsigned OPT_BUTTON = 1;

    typedef struct packed {
        logic [DELAY_W-1:0] trigger_hold;
        logic [DELAY_W-1:0] signal_delay;
        logic [DELAY_W-1:0] signal_hold;
        logic [DELAY_W-1:0] reset_delay;
        logic [DELAY_W-1:0] button_delay;
        logic [DELAY_W-1:0] relay_phase;
        logic [DELAY_W-1:0] rearm_wait;
        logic [OPT_W-1:0]   options;
    } t_cfg;

    typedef struct packed {
        logic signal_lamp;
        logic relay_enable;
        logic ac_relay_a;
        logic ac_relay_b;
        logic busy;
    } t_result;

    // (64 * d) >> 8 in 32-bit arithmetic; the constant multiply is a shift
    function automatic logic [TIME_W-1:0] scale_delay(input logic [DELAY_W-1:0] d);
        logic [TIME_W-1:0] prod;
        prod = TIME_W'(d) * SCALE_FACTOR;
        return prod >> SCALE_SHIFT;
    endfunction

endpackage

/* rtl/rrs_cfg.sv */
module rrs_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [rrs_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [rrs_pkg::DELAY_W-1:0]   i_cfg_wdata,
    output rrs_pkg::t_cfg                 o_cfg
);
    import rrs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_hold <= RST_TRIGGER_HOLD;
            r_cfg.signal_delay <= RST_SIGNAL_DELAY;
            r_cfg.signal_hold  <= RST_SIGNAL_HOLD;
            r_cfg.reset_delay  <= RST_RESET_DELAY;
            r_cfg.button_delay <= RST_BUTTON_DELAY;
            r_cfg.relay_phase  <= RST_RELAY_PHASE;
            r_cfg.rearm_wait   <= RST_REARM_WAIT;
            r_cfg.options      <= RST_OPTIONS;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_TRIGGER_HOLD: r_cfg.trigger_hold <= i_cfg_wdata;
                REG_SIGNAL_DELAY: r_cfg.signal_delay <= i_cfg_wdata;
                REG_SIGNAL_HOLD:  r_cfg.signal_hold  <= i_cfg_wdata;
                REG_RESET_DELAY:  r_cfg.reset_delay  <= i_cfg_wdata;
                REG_BUTTON_DELAY: r_cfg.button_delay <= i_cfg_wdata;
                REG_RELAY_PHASE:  r_cfg.relay_phase  <= i_cfg_wdata;
                REG_REARM_WAIT:   r_cfg.rearm_wait   <= i_cfg_wdata;
                REG_OPTIONS:      r_cfg.options      <= i_cfg_wdata[OPT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/rrs_core.sv */
module rrs_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [rrs_pkg::TIME_W-1:0] i_now,
    input  logic                       i_trigger_level,
    input  logic                       i_button_level,
    input  rrs_pkg::t_cfg              i_cfg,
    output rrs_pkg::t_result           o_result
);
    import rrs_pkg::*;

    logic [TIME_W-1:0] r_active_since, n_active_since;
    logic              r_running,      n_running;
    logic              r_await_btn,    n_await_btn;
    logic [TIME_W-1:0] r_lamp_on,      n_lamp_on;
    logic [TIME_W-1:0] r_lamp_off,     n_lamp_off;
    logic [TIME_W-1:0] r_ph_start,     n_ph_start;
    logic [TIME_W-1:0] r_ph_end,       n_ph_end;
    logic [TIME_W-1:0] r_rearm,        n_rearm;
    logic [3:0]        r_pins,         n_pins;  // bit0 lamp, bit1 enable, bit2 A, bit3 B

    always_comb begin
        logic trig_active;
        logic pressed;
        logic lamp_present;
        logic btn_present;
        logic start;

        trig_active  = !i_trigger_level;
        pressed      = !i_button_level;
        lamp_present = i_cfg.options[OPT_LAMP];
        btn_present  = i_cfg.options[OPT_BUTTON];
        start        = 1'b0;

        n_active_since = r_active_since;
        n_running      = r_running;
        n_await_btn    = r_await_btn;
        n_lamp_on      = r_lamp_on;
        n_lamp_off     = r_lamp_off;
        n_ph_start     = r_ph_start;
        n_ph_end       = r_ph_end;
        n_rearm        = r_rearm;
        n_pins         = r_pins;

        // qualify the trigger; zero marks "no active edge seen"
        if (!r_running) begin
            if (!trig_active) begin
                n_active_since = '0;
            end else begin
                if (n_active_since == '0) begin
                    n_active_since = i_now;
                end
                if ((i_now - n_active_since) >= TIME_W'(i_cfg.trigger_hold)) begin
                    start = 1'b1;
                end
            end
        end

        if (start) begin
            n_running  = 1'b1;
            n_lamp_on  = i_now + scale_delay(i_cfg.signal_delay);
            n_lamp_off = n_lamp_on + scale_delay(i_cfg.signal_hold);
            if (!btn_present) begin
                n_ph_start = i_now + scale_delay(i_cfg.reset_delay);
                n_ph_end   = n_ph_start + TIME_W'(i_cfg.relay_phase);
            end else begin
                n_await_btn = 1'b1;
            end
        end

        if (n_await_btn && pressed) begin
            n_ph_start  = i_now + scale_delay(i_cfg.button_delay);
            n_ph_end    = n_ph_start + TIME_W'(i_cfg.relay_phase);
            n_await_btn = 1'b0;
        end

        if (n_running) begin
            if (n_lamp_on != '0 && i_now > n_lamp_on && lamp_present) begin
                n_pins[0] = 1'b0;
                n_lamp_on = '0;
            end
            if (n_lamp_off != '0 && i_now > n_lamp_off && lamp_present) begin
                n_pins[0]  = 1'b1;
                n_lamp_off = '0;
            end
            if (n_ph_start != '0 && i_now >= n_ph_start && !n_await_btn) begin
                n_pins[1] = 1'b0;
                n_pins[2] = i_now[PHASE_BIT];
                n_pins[3] = !i_now[PHASE_BIT];
            end
            // phase end wins over phase start in the same tick
            if (n_ph_end != '0 && i_now >= n_ph_end && !n_await_btn) begin
                n_rearm     = i_now + TIME_W'(i_cfg.rearm_wait);
                n_ph_start  = '0;
                n_ph_end    = '0;
                n_pins[3:1] = 3'b111;
            end
            if (n_rearm != '0 && i_now > n_rearm) begin
                n_running = 1'b0;
                n_rearm   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_since <= '0;
            r_running      <= 1'b0;
            r_await_btn    <= 1'b0;
            r_lamp_on      <= '0;
            r_lamp_off     <= '0;
            r_ph_start     <= '0;
            r_ph_end       <= '0;
            r_rearm        <= '0;
            r_pins         <= '1;
        end else if (i_step) begin
            r_active_since <= n_active_since;
            r_running      <= n_running;
            r_await_btn    <= n_await_btn;
            r_lamp_on      <= n_lamp_on;
            r_lamp_off     <= n_lamp_off;
            r_ph_start     <= n_ph_start;
            r_ph_end       <= n_ph_end;
            r_rearm        <= n_rearm;
            r_pins         <= n_pins;
        end
    end

    assign o_result.signal_lamp  = n_pins[0];
    assign o_result.relay_enable = n_pins[1];
    assign o_result.ac_relay_a   = n_pins[2];
    assign o_result.ac_relay_b   = n_pins[3];
    assign o_result.busy         = n_running;

endmodule

/* rtl/relay_release_sequencer.sv */
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+-----------------------------------------------
// tick in  | i_in_valid / o_in_ready       | i_now_ms, i_trigger_level, i_button_level
// pins out | o_out_valid / i_out_ready     | o_signal_lamp, o_relay_enable, o_ac_relay_a,
//          |                               | o_ac_relay_b, o_busy_res
// config   | i_cfg_wr_en (no wait)         | i_cfg_index, i_cfg_wdata
//
// One tick per cycle sustained while results are taken; a result is offered once its tick
// has passed the input register, then one pass of the step logic into the result register.
// Reset is synchronous, active low: defaults load, schedule clears, core pins go high.
// A stalled result holds; the input register still takes a tick while the result
// register drains, and o_in_ready drops only when both are full and the result is held.
module relay_release_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rrs_pkg::TIME_W-1:0]    i_now_ms,
    input  logic                          i_trigger_level,
    input  logic                          i_button_level,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_signal_lamp,
    output logic                          o_relay_enable,
    output logic                          o_ac_relay_a,
    output logic                          o_ac_relay_b,
    output logic                          o_busy_res,
    input  logic                          i_cfg_wr_en,
    input  logic [rrs_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [rrs_pkg::DELAY_W-1:0]   i_cfg_wdata
);
    import rrs_pkg::*;

    t_cfg              cfg;
    t_result           step_res;
    logic              r_in_valid;
    logic [TIME_W-1:0] r_now;
    logic              r_trig;
    logic              r_btn;
    logic              r_out_valid;
    t_result           r_res;
    logic              advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    rrs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    rrs_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_now           (r_now),
        .i_trigger_level (r_trig),
        .i_button_level  (r_btn),
        .i_cfg           (cfg),
        .o_result        (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_now  <= i_now_ms;
            r_trig <= i_trigger_level;
            r_btn  <= i_button_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_signal_lamp  = r_res.signal_lamp;
    assign o_relay_enable = r_res.relay_enable;
    assign o_ac_relay_a   = r_res.ac_relay_a;
    assign o_ac_relay_b   = r_res.ac_relay_b;
    assign o_busy_res     = r_res.busy;

    // during the relay phase the AC relays stand opposite
    a_phase_opposite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_relay_enable) |-> (o_ac_relay_a != o_ac_relay_b))
        else $error("AC relays not opposite during relay phase");

    // relays are enabled only inside a running sequence
    a_enable_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_relay_enable) |-> o_busy_res)
        else $error("relay enabled while no sequence runs");

    // input stage stalls only when both stages are full and the output is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a held result");

endmodule

/* sim/relay_release_sequencer_tb.sv */
module relay_release_sequencer_tb;
    import rrs_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int IDLE_PCT        = 9;
    localparam int RX_PERIOD       = 1000;
    localparam int RX_CLEAR_SPAN   = 300;
    localparam int RX_HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES    = 6;
    localparam int REPORT_MAX      = 10;
    localparam int N_ROWS          = 21;

    localparam t_result PINS_IDLE = 5'b11110;
    localparam t_result PINS_BUSY = 5'b11111;

    localparam t_reg_idx DELAY_REGS [7] = '{
        REG_TRIGGER_HOLD, REG_SIGNAL_DELAY, REG_SIGNAL_HOLD, REG_RESET_DELAY,
        REG_BUTTON_DELAY, REG_RELAY_PHASE, REG_REARM_WAIT
    };

    typedef struct {
        logic [TIME_W-1:0] tick_ms;
        logic              trig;
        logic              btn;
        bit                typed;
        t_result           want;
    } t_tick_row;

    // defaults: hold 500, lamp 900+500 .. +1250, relay phase 1900 .. 3900, rearm to 4900
    t_tick_row rows [N_ROWS] = '{
        '{32'h0000_0000, 1'b1, 1'b1, 1'b1, PINS_IDLE},
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, PINS_IDLE},
        '{32'h0000_0000, 1'b0, 1'b1, 1'b1, PINS_IDLE},   // active at time zero: hold restarts
        '{32'd400,       1'b0, 1'b1, 1'b1, PINS_IDLE},
        '{32'd899,       1'b0, 1'b1, 1'b1, PINS_IDLE},
        '{32'd900,       1'b0, 1'b1, 1'b1, PINS_BUSY},
        '{32'd1400,      1'b1, 1'b1, 1'b0, PINS_IDLE},
        '{32'd1401,      1'b1, 1'b1, 1'b0, PINS_IDLE},
        '{32'd1900,      1'b1, 1'b0, 1'b0, PINS_IDLE},
        '{32'd2000,      1'b1, 1'b1, 1'b0, PINS_IDLE},
        '{32'd2651,      1'b1, 1'b1, 1'b0, PINS_IDLE},
        '{32'd3900,      1'b1, 1'b1, 1'b0, PINS_IDLE},
        '{32'd4900,      1'b0, 1'b1, 1'b1, PINS_BUSY},
        '{32'd4901,      1'b0, 1'b1, 1'b1, PINS_IDLE},
        '{32'd4902,      1'b0, 1'b1, 1'b0, PINS_IDLE},   // trigger held over the lockout
        '{32'hFFFF_FF00, 1'b1, 1'b1, 1'b0, PINS_IDLE},   // trigger released near the top of the time range
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, PINS_IDLE},
        '{32'h0000_0000, 1'b1, 1'b1, 1'b0, PINS_IDLE},
        '{32'h0000_0300, 1'b0, 1'b0, 1'b0, PINS_IDLE},
        '{32'h8000_0000, 1'b0, 1'b0, 1'b0, PINS_IDLE},
        '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, PINS_IDLE}
    };

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic [TIME_W-1:0]    i_now_ms        = '0;
    logic                 i_trigger_level = 1'b1;
    logic                 i_button_level  = 1'b1;
    logic                 i_out_ready     = 1'b0;
    logic                 i_cfg_wr_en     = 1'b0;
    logic [REG_IDX_W-1:0] i_cfg_index     = '0;
    logic [DELAY_W-1:0]   i_cfg_wdata     = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_signal_lamp;
    logic                 o_relay_enable;
    logic                 o_ac_relay_a;
    logic                 o_ac_relay_b;
    logic                 o_busy_res;

    relay_release_sequencer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_now_ms        (i_now_ms),
        .i_trigger_level (i_trigger_level),
        .i_button_level  (i_button_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_signal_lamp   (o_signal_lamp),
        .o_relay_enable  (o_relay_enable),
        .o_ac_relay_a    (o_ac_relay_a),
        .o_ac_relay_b    (o_ac_relay_b),
        .o_busy_res      (o_busy_res),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // sequencer state as the block should hold it
    t_cfg              seq_cfg = '{RST_TRIGGER_HOLD, RST_SIGNAL_DELAY, RST_SIGNAL_HOLD,
                                   RST_RESET_DELAY, RST_BUTTON_DELAY, RST_RELAY_PHASE,
                                   RST_REARM_WAIT, RST_OPTIONS};
    logic [TIME_W-1:0] armed_since    = '0;
    logic              seq_running    = 1'b0;
    logic              wait_button    = 1'b0;
    logic [TIME_W-1:0] lamp_on_at     = '0;
    logic [TIME_W-1:0] lamp_off_at    = '0;
    logic [TIME_W-1:0] phase_start_at = '0;
    logic [TIME_W-1:0] phase_end_at   = '0;
    logic [TIME_W-1:0] rearm_at       = '0;
    logic              pin_lamp       = 1'b1;
    logic              pin_enable     = 1'b1;
    logic              pin_a          = 1'b1;
    logic              pin_b          = 1'b1;

    t_result           pins_due_q [$];
    bit                tick_typed = 1'b0;
    t_result           tick_want  = PINS_IDLE;
    int                tx_idle_pct = IDLE_PCT;
    logic [TIME_W-1:0] last_ms = '0;
    int                fail_count = 0;
    int                pins_seen = 0;
    int                cycle_cnt = 0;

    function automatic logic [TIME_W-1:0] quarter_ms(input logic [DELAY_W-1:0] d);
        return {{(TIME_W-DELAY_W+2){1'b0}}, d[DELAY_W-1:2]};
    endfunction

    function automatic t_result step_release(input logic [TIME_W-1:0] tick_ms,
                                             input logic trig_lvl, input logic btn_lvl);
        logic start;
        logic lamp_fitted;
        logic btn_fitted;
        start       = 1'b0;
        lamp_fitted = seq_cfg.options[OPT_LAMP];
        btn_fitted  = seq_cfg.options[OPT_BUTTON];

        if (!seq_running) begin
            if (trig_lvl) begin
                armed_since = '0;
            end else begin
                if (armed_since == '0)
                    armed_since = tick_ms;
                if (tick_ms - armed_since >= TIME_W'(seq_cfg.trigger_hold))
                    start = 1'b1;
            end
        end

        if (start) begin
            seq_running = 1'b1;
            lamp_on_at  = tick_ms + quarter_ms(seq_cfg.signal_delay);
            lamp_off_at = lamp_on_at + quarter_ms(seq_cfg.signal_hold);
            if (!btn_fitted) begin
                phase_start_at = tick_ms + quarter_ms(seq_cfg.reset_delay);
                phase_end_at   = phase_start_at + TIME_W'(seq_cfg.relay_phase);
            end else begin
                wait_button = 1'b1;
            end
        end

        if (wait_button && !btn_lvl) begin
            phase_start_at = tick_ms + quarter_ms(seq_cfg.button_delay);
            phase_end_at   = phase_start_at + TIME_W'(seq_cfg.relay_phase);
            wait_button    = 1'b0;
        end

        if (seq_running) begin
            if (lamp_on_at != '0 && tick_ms > lamp_on_at && lamp_fitted) begin
                pin_lamp   = 1'b0;
                lamp_on_at = '0;
            end
            if (lamp_off_at != '0 && tick_ms > lamp_off_at && lamp_fitted) begin
                pin_lamp    = 1'b1;
                lamp_off_at = '0;
            end
            if (phase_start_at != '0 && tick_ms >= phase_start_at && !wait_button) begin
                pin_enable = 1'b0;
                pin_a      = tick_ms[PHASE_BIT];
                pin_b      = ~tick_ms[PHASE_BIT];
            end
            // the end of the phase overrides a start in the same tick
            if (phase_end_at != '0 && tick_ms >= phase_end_at && !wait_button) begin
                rearm_at       = tick_ms + TIME_W'(seq_cfg.rearm_wait);
                phase_start_at = '0;
                phase_end_at   = '0;
                pin_enable     = 1'b1;
                pin_a          = 1'b1;
                pin_b          = 1'b1;
            end
            if (rearm_at != '0 && tick_ms > rearm_at) begin
                seq_running = 1'b0;
                rearm_at    = '0;
            end
        end

        return {pin_lamp, pin_enable, pin_a, pin_b, seq_running};
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("pin mismatch at result %0d: %s", pins_seen, msg);
    endtask

    task automatic cmp_pin(input string name, input logic want, input logic got);
        if (got !== want)
            note_failure($sformatf("%s expected %b actual %b", name, want, got));
    endtask

    task automatic check_pins(input t_result got);
        t_result want;
        if (pins_due_q.size() == 0) begin
            note_failure("result transfer with no tick pending");
        end else begin
            want = pins_due_q.pop_front();
            cmp_pin("signal_lamp", want.signal_lamp, got.signal_lamp);
            cmp_pin("relay_enable", want.relay_enable, got.relay_enable);
            cmp_pin("ac_relay_a", want.ac_relay_a, got.ac_relay_a);
            cmp_pin("ac_relay_b", want.ac_relay_b, got.ac_relay_b);
            cmp_pin("busy_res", want.busy, got.busy);
        end
        pins_seen++;
    endtask

    // check the oldest result first, then predict the tick taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                check_pins({o_signal_lamp, o_relay_enable, o_ac_relay_a, o_ac_relay_b,
                            o_busy_res});
            if (i_in_valid && o_in_ready) begin
                if (tick_typed) begin
                    void'(step_release(i_now_ms, i_trigger_level, i_button_level));
                    pins_due_q.push_back(tick_want);
                end else begin
                    pins_due_q.push_back(step_release(i_now_ms, i_trigger_level,
                                                      i_button_level));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, a clear stretch and one long hold-off per period
    initial begin : rx_side
        int rx_cycles;
        rx_cycles = 0;
        forever begin
            @(negedge i_clk);
            rx_cycles++;
            if (rx_cycles % RX_PERIOD == RX_PERIOD / 2) begin
                i_out_ready <= 1'b0;
                for (int k = 0; k < RX_HOLD_CYCLES; k++)
                    @(negedge i_clk);
                rx_cycles += RX_HOLD_CYCLES;
            end else if (rx_cycles % RX_PERIOD < RX_CLEAR_SPAN) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_tick(input logic [TIME_W-1:0] tick_ms, input logic trig,
                             input logic btn, input bit typed, input t_result want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_now_ms        <= tick_ms;
        i_trigger_level <= trig;
        i_button_level  <= btn;
        tick_typed = typed;
        tick_want  = want;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [DELAY_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_TRIGGER_HOLD: seq_cfg.trigger_hold = val;
            REG_SIGNAL_DELAY: seq_cfg.signal_delay = val;
            REG_SIGNAL_HOLD:  seq_cfg.signal_hold  = val;
            REG_RESET_DELAY:  seq_cfg.reset_delay  = val;
            REG_BUTTON_DELAY: seq_cfg.button_delay = val;
            REG_RELAY_PHASE:  seq_cfg.relay_phase  = val;
            REG_REARM_WAIT:   seq_cfg.rearm_wait   = val;
            REG_OPTIONS:      seq_cfg.options      = val[OPT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int ph);
        logic [DELAY_W-1:0] dly;
        logic [DELAY_W-1:0] biggest;
        logic [TIME_W-1:0]  step_cap;
        logic [TIME_W-1:0]  t_ms;
        logic [OPT_W-1:0]   opt;
        logic               trig_l;
        logic               btn_l;
        logic               trig_d;
        int                 trig_left;
        int                 btn_left;
        biggest   = '0;
        trig_l    = 1'b1;
        btn_l     = 1'b1;
        trig_left = 0;
        btn_left  = 0;

        // drain before touching the registers; any running sequence carries over
        i_in_valid <= 1'b0;
        while (pins_due_q.size() != 0)
            @(negedge i_clk);
        for (int i = 0; i < 7; i++) begin
            case (ph % 4)
                0:       dly = DELAY_W'($urandom_range(i == 0 ? 600 : 2000));
                1:       dly = '0;
                2:       dly = '1;
                default: dly = DELAY_W'($urandom);
            endcase
            if (dly > biggest)
                biggest = dly;
            write_reg(DELAY_REGS[i], dly);
        end
        opt = OPT_W'((ph + ph / 4) % 4);
        write_reg(REG_OPTIONS, {(DELAY_W-OPT_W)'($urandom), opt});
        i_cfg_wr_en <= 1'b0;

        tx_idle_pct = (ph == 2) ? 0 : IDLE_PCT;
        step_cap    = TIME_W'(biggest >> 4) + 4;
        if (ph % 5 == 4)
            t_ms = TIME_W'(0) - step_cap * 80;    // start below the time wrap so the phase can cross it
        else if (ph % 2 == 1)
            t_ms = last_ms;
        else
            t_ms = $urandom;

        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (trig_left == 0) begin
                trig_l    = ($urandom_range(99) < 30);
                trig_left = trig_l ? $urandom_range(1, 20) : $urandom_range(1, 80);
            end
            trig_left--;
            if (btn_left == 0) begin
                btn_l    = ($urandom_range(99) < 85);
                btn_left = btn_l ? $urandom_range(1, 40) : $urandom_range(1, 4);
            end
            btn_left--;
            if ($urandom_range(99) < 2)
                t_ms = $urandom;
            else
                t_ms += $urandom_range(step_cap);
            trig_d = ($urandom_range(99) == 0) ? ~trig_l : trig_l;
            send_tick(t_ms, trig_d, btn_l, 1'b0, PINS_IDLE);
        end
        last_ms = t_ms;
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < N_ROWS; r++)
            send_tick(rows[r].tick_ms, rows[r].trig, rows[r].btn, rows[r].typed,
                      rows[r].want);
        for (int ph = 0; ph < PHASES; ph++)
            run_phase(ph);
        i_in_valid <= 1'b0;
        while (pins_due_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pins_due_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/rrs_pkg.sv
rtl/rrs_cfg.sv
rtl/rrs_core.sv
rtl/relay_release_sequencer.sv
sim/relay_release_sequencer_tb.sv
